// File: rtl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package pds_pkg;

  localparam int REF_W  = 17;
  localparam int TGT_W  = 18;
  localparam int MC_W   = 8;
  localparam int PC_W   = 6;
  localparam int SC_W   = 2;
  localparam int WORD_W = 20;
  localparam int CLK_W  = 19;
  localparam int CFG_IDX_W = 2;

  // shared divider widths: ref*m tops out below 2^26
  localparam int DVD_W = 26;
  localparam int DVS_W = 17;
  localparam int MUL_W = 27;

  localparam int FVCO_LIMIT = 170000;
  localparam int M_MIN      = 8;
  localparam int M_MAX      = 263;
  localparam int P_MIN      = 2;
  localparam int P_MAX      = 49;
  localparam int P_HI_DIV   = 1000;

  // ref/1000 as (ref * P_RECIP) >> P_RECIP_SH, exact for any 17-bit ref
  localparam int P_RECIP    = 134218;
  localparam int P_RECIP_W  = 18;
  localparam int P_RECIP_SH = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_REF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DFLT = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/pds_in_if.sv
// Request channel: valid/ready handshake carrying the requested clock.
// Depends on pds_pkg for field widths.
`timescale 1ns / 1ps

interface pds_in_if import pds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_khz;

  modport source (output valid, output target_khz, input ready);
  modport sink   (input valid, input target_khz, output ready);
endinterface

// File: rtl/pds_out_if.sv
// Result channel: valid/ready handshake carrying the chosen PLL setting.
// Depends on pds_pkg for field widths.
`timescale 1ns / 1ps

interface pds_out_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MC_W-1:0]   m_code;
  logic [PC_W-1:0]   p_code;
  logic [SC_W-1:0]   s_code;
  logic [WORD_W-1:0] pll_word;
  logic [CLK_W-1:0]  achieved_khz;
  logic              found;

  modport source (output valid, output m_code, output p_code, output s_code,
                  output pll_word, output achieved_khz, output found, input ready);
  modport sink   (input valid, input m_code, input p_code, input s_code,
                  input pll_word, input achieved_khz, input found, output ready);
endinterface

// File: rtl/pds_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pds_pkg (div_req_t / div_rsp_t).
`timescale 1ns / 1ps

module pds_div import pds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   sub;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  // remainder stays below the divisor, so the shifted value fits DVS_W+1 bits
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign sub     = shifted - {1'b0, req.divisor};
  assign ge      = shifted >= {1'b0, req.divisor};
  assign rem_nxt = ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
        rem_r  <= '0;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DVD_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: rtl/pll_divider_search.sv
// PLL m/p/s divider search: top level with config registers and sequencer.
// Depends on pds_pkg, pds_in_if, pds_out_if and pds_div.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one transaction carries target_khz. A request outside
//            [min_target_khz, max_target_khz] is replaced by the default.
//   out_ch : one transaction per request with m/p/s codes, the packed PLL
//            word, the achieved clock and the found flag (all zero if not).
//   cfg_*  : write-only registers, one per cycle while cfg_we is high;
//            write only while no request is in flight.
// Timing
//   The p range comes from a reciprocal multiply at acceptance. Each m bound
//   and each candidate clock goes through one multiplier and a shared
//   bit-serial divider. out_ch.valid rises after the two m-bound divisions
//   and N = s_hi * (p_hi - p_lo + 1) * (m_hi - m_lo + 1) candidate divisions,
//   N = 0 when either range is empty.
//   With ref_khz = 0 it rises in the cycle after acceptance.
//   in_ch.ready is high only while idle: one request at a time, the next
//   one taken only once the previous result is taken and the block is idle.
// Reset / stall
//   Synchronous reset returns to idle and loads the register defaults.
//   The result holds on out_ch until taken; no new request is accepted
//   until then.
module pll_divider_search import pds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pds_in_if.sink               in_ch,
  pds_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TGT_W-1:0]     cfg_wdata
);

  localparam int RSC_W = REF_W + P_RECIP_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_t;
  typedef enum logic [1:0] {PH_MHI, PH_MLO, PH_CAND} phase_t;

  state_t state_r;
  phase_t phase_r;

  logic [REF_W-1:0] ref_r;
  logic [TGT_W-1:0] min_r, max_r, dflt_r;

  logic [TGT_W-1:0] tgt_r;
  logic [2:0]       s_hi_r, s_r;
  logic [6:0]       p_lo_r;
  logic [5:0]       p_hi_r, p_r;
  logic [8:0]       m_lo_r, m_hi_r, m_r;

  logic [DVD_W-1:0] product_r;
  logic [DVS_W-1:0] divisor_r;
  logic             div_start_r;

  logic [TGT_W-1:0] best_diff_r;
  logic [CLK_W-1:0] best_clk_r;
  logic [MC_W-1:0]  m_code_r;
  logic [PC_W-1:0]  p_code_r;
  logic [SC_W-1:0]  s_code_r;
  logic             found_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= REF_W'(10000);
      min_r  <= TGT_W'(10000);
      max_r  <= TGT_W'(66000);
      dflt_r <= TGT_W'(60000);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REF:  ref_r  <= cfg_wdata[REF_W-1:0];
        CFG_MIN:  min_r  <= cfg_wdata;
        CFG_MAX:  max_r  <= cfg_wdata;
        CFG_DFLT: dflt_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // ---------------- request pre-processing ----------------
  logic [TGT_W-1:0] tgt_sel;
  logic [2:0]       s_hi_sel;

  assign tgt_sel = (in_ch.target_khz < min_r || in_ch.target_khz > max_r) ?
                   dflt_r : in_ch.target_khz;

  // largest s in 1..4 keeping target*2^(s-1) below the VCO limit, else 1
  always_comb begin
    s_hi_sel = 3'd1;
    for (int s = 2; s <= 4; s++) begin
      if (({3'b000, tgt_sel} << (s - 1)) < 21'(FVCO_LIMIT)) s_hi_sel = 3'(s);
    end
  end

  // p range from ref/1000; ref/1000 is at most 131, so eight bits carry it
  logic [RSC_W-1:0] ref_scaled;
  logic [7:0]       ref_k;
  logic [5:0]       p_hi_new;
  logic [6:0]       p_lo_half, p_lo_new;

  assign ref_scaled = RSC_W'(ref_r) * RSC_W'(P_RECIP);
  assign ref_k      = ref_scaled[P_RECIP_SH +: 8];
  assign p_hi_new   = (ref_k > 8'(P_MAX)) ? 6'(P_MAX) : ref_k[5:0];
  assign p_lo_half  = ref_k[7:1];
  assign p_lo_new   = (p_lo_half < 7'(P_MIN)) ? 7'(P_MIN) : p_lo_half;

  // ---------------- shared multiplier operand select ----------------
  logic [TGT_W-1:0] mul_a;
  logic [8:0]       mul_b;
  logic [1:0]       mul_sh;
  logic [DVS_W-1:0] mul_dvs;
  logic [8:0]       den;
  logic [MUL_W-1:0] mul_full;
  logic [MUL_W-1:0] mul_shift;

  assign den = {3'b000, p_r} << (s_r - 3'd1);

  always_comb begin
    case (phase_r)
      PH_MHI: begin
        mul_a   = tgt_r;
        mul_b   = {3'b000, p_hi_r};
        mul_sh  = 2'(s_hi_r - 3'd1);
        mul_dvs = ref_r;
      end
      PH_MLO: begin
        mul_a   = tgt_r;
        mul_b   = {2'b00, p_lo_r};
        mul_sh  = 2'd0;
        mul_dvs = ref_r;
      end
      PH_CAND: begin
        mul_a   = {1'b0, ref_r};
        mul_b   = m_r;
        mul_sh  = 2'd0;
        mul_dvs = {8'd0, den};
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = 2'd0;
        mul_dvs = ref_r;
      end
    endcase
  end

  assign mul_full  = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign mul_shift = mul_full << mul_sh;

  // ---------------- divider result handling ----------------
  logic [DVD_W-1:0] quot;
  logic [DVD_W-1:0] tgt_ext;
  logic [DVD_W-1:0] diff;
  logic             better;
  logic [8:0]       m_hi_new, m_lo_new;
  logic             empty;

  assign quot    = div_rsp.quotient;
  assign tgt_ext = DVD_W'(tgt_r);
  assign diff    = (quot > tgt_ext) ? quot - tgt_ext : tgt_ext - quot;
  assign better  = diff < DVD_W'(best_diff_r);

  assign m_hi_new = (quot > DVD_W'(M_MAX)) ? 9'(M_MAX) : quot[8:0];
  // one above M_MAX marks an empty m range
  assign m_lo_new = (quot > DVD_W'(M_MAX)) ? 9'(M_MAX + 1) :
                    (quot < DVD_W'(M_MIN)) ? 9'(M_MIN) : quot[8:0];
  assign empty    = ({1'b0, p_hi_r} < p_lo_r) || (m_lo_new > m_hi_r);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MHI;
      div_start_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            tgt_r       <= tgt_sel;
            s_hi_r      <= s_hi_sel;
            p_hi_r      <= p_hi_new;
            p_lo_r      <= p_lo_new;
            best_diff_r <= tgt_sel;
            best_clk_r  <= '0;
            m_code_r    <= '0;
            p_code_r    <= '0;
            s_code_r    <= '0;
            found_r     <= 1'b0;
            phase_r     <= PH_MHI;
            state_r     <= (ref_r == '0) ? ST_OUT : ST_MUL;
          end
        end
        ST_MUL: begin
          product_r   <= mul_shift[DVD_W-1:0];
          divisor_r   <= mul_dvs;
          div_start_r <= 1'b1;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            case (phase_r)
              PH_MHI: begin
                m_hi_r  <= m_hi_new;
                phase_r <= PH_MLO;
                state_r <= ST_MUL;
              end
              PH_MLO: begin
                m_lo_r <= m_lo_new;
                if (empty) begin
                  state_r <= ST_OUT;
                end else begin
                  s_r     <= s_hi_r;
                  p_r     <= p_lo_r[5:0];
                  m_r     <= m_hi_r;
                  phase_r <= PH_CAND;
                  state_r <= ST_MUL;
                end
              end
              PH_CAND: begin
                if (better) begin
                  best_diff_r <= diff[TGT_W-1:0];
                  best_clk_r  <= quot[CLK_W-1:0];
                  m_code_r    <= MC_W'(m_r - 9'(M_MIN));
                  p_code_r    <= PC_W'(p_r - 6'(P_MIN));
                  s_code_r    <= SC_W'(s_r - 3'd1);
                  found_r     <= 1'b1;
                end
                // walk m down, then p up, then s down
                if (m_r > m_lo_r) begin
                  m_r     <= m_r - 9'd1;
                  state_r <= ST_MUL;
                end else begin
                  m_r <= m_hi_r;
                  if (p_r < p_hi_r) begin
                    p_r     <= p_r + 6'd1;
                    state_r <= ST_MUL;
                  end else begin
                    p_r <= p_lo_r[5:0];
                    if (s_r > 3'd1) begin
                      s_r     <= s_r - 3'd1;
                      state_r <= ST_MUL;
                    end else begin
                      state_r <= ST_OUT;
                    end
                  end
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_OUT: begin
          if (out_ch.ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign div_req.start    = div_start_r;
  assign div_req.dividend = product_r;
  assign div_req.divisor  = divisor_r;

  pds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- channel outputs ----------------
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = (state_r == ST_OUT);
  assign out_ch.m_code       = m_code_r;
  assign out_ch.p_code       = p_code_r;
  assign out_ch.s_code       = s_code_r;
  assign out_ch.pll_word     = {m_code_r, 2'b00, p_code_r, 2'b00, s_code_r};
  assign out_ch.achieved_khz = best_clk_r;
  assign out_ch.found        = found_r;

  // ---------------- assertions ----------------
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request accepted while a result is pending");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_start_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == ST_DIV) && ($past(state_r) == ST_MUL))
    else $error("divider start outside the multiply/divide sequence");

  a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |->
      (out_ch.pll_word == '0) && (out_ch.achieved_khz == '0))
    else $error("result fields nonzero without a found setting");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for pll_divider_search: a directed request table, then random
// register settings and requests; results checked field by field vs. table or local search.
// Depends on rtl/pds_pkg.sv, rtl/pds_in_if.sv, rtl/pds_out_if.sv and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import pds_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int P_LO_DIV        = 2000;
  localparam int S_TOP           = 4;
  localparam int IDLE_LIMIT      = 400000;
  localparam int END_PAUSE       = 200;
  localparam int N_DIRECTED      = 22;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 13;
  localparam int MAX_STALL       = 40;

  typedef struct packed {
    logic [MC_W-1:0]   m_code;
    logic [PC_W-1:0]   p_code;
    logic [SC_W-1:0]   s_code;
    logic [WORD_W-1:0] pll_word;
    logic [CLK_W-1:0]  achieved_khz;
    logic              found;
  } pll_result_t;

  typedef struct packed {
    logic [TGT_W-1:0] ref_w;
    logic [TGT_W-1:0] min_w;
    logic [TGT_W-1:0] max_w;
    logic [TGT_W-1:0] dflt_w;
    logic [TGT_W-1:0] target;
    logic             typed;
    pll_result_t      exp;
  } req_row_t;

  localparam pll_result_t NOT_FOUND = '0;
  // ref 2000, p = 2: first candidate s = 4, m = 64 lands exactly on 8000
  localparam pll_result_t HIT_8000 = {8'd56, 6'd0, 2'd3, 20'd229379, 19'd8000, 1'b1};

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TGT_W-1:0]     cfg_wdata;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pll_divider_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // local copy of the register file
  logic [REF_W-1:0] cfg_ref  = REF_W'(10000);
  logic [TGT_W-1:0] cfg_min  = TGT_W'(10000);
  logic [TGT_W-1:0] cfg_max  = TGT_W'(66000);
  logic [TGT_W-1:0] cfg_dflt = TGT_W'(60000);

  pll_result_t queued_settings[$];
  req_row_t    dir_rows [N_DIRECTED];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  not_found     = 0;
  int  requests_sent = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  src_active    = 1'b0;
  int  stall_left    = 0;
  int  rx_mode       = 0;
  int  idle_cycles   = 0;

  function automatic pll_result_t search_divider(input logic [TGT_W-1:0] request);
    longint unsigned tgt, rf, p_lo, p_hi, s_hi, m_lo, m_hi, den, clk_k, diff;
    longint unsigned best_diff, best_clk, best_m, best_p, best_s;
    longint s, p, m;
    bit hit, got_s;
    pll_result_t res;
    tgt = 64'(request);
    rf  = 64'(cfg_ref);
    if (tgt < cfg_min || tgt > cfg_max) tgt = 64'(cfg_dflt);
    p_hi = rf / P_HI_DIV;
    if (p_hi > P_MAX) p_hi = P_MAX;
    p_lo = rf / P_LO_DIV;
    if (p_lo < P_MIN) p_lo = P_MIN;
    // widest post-divider that keeps the VCO under its limit
    s_hi  = 1;
    got_s = 1'b0;
    for (s = S_TOP; s >= 1; s--)
      if (!got_s && (tgt << (s - 1)) < FVCO_LIMIT) begin
        s_hi  = s;
        got_s = 1'b1;
      end
    best_diff = tgt;
    best_clk  = 0;
    best_m    = M_MIN;
    best_p    = P_MIN;
    best_s    = 1;
    hit       = 1'b0;
    if (rf != 0) begin
      m_hi = ((tgt * p_hi) << (s_hi - 1)) / rf;
      if (m_hi > M_MAX) m_hi = M_MAX;
      m_lo = (tgt * p_lo) / rf;
      if (m_lo < M_MIN) m_lo = M_MIN;
      for (s = longint'(s_hi); s >= 1; s--)
        for (p = longint'(p_lo); p <= longint'(p_hi); p++) begin
          den = p << (s - 1);
          for (m = longint'(m_hi); m >= longint'(m_lo); m--) begin
            clk_k = (rf * m) / den;
            diff  = (clk_k > tgt) ? clk_k - tgt : tgt - clk_k;
            if (diff < best_diff) begin
              best_diff = diff;
              best_clk  = clk_k;
              best_m    = m;
              best_p    = p;
              best_s    = s;
              hit       = 1'b1;
            end
          end
        end
    end
    res = '0;
    if (hit) begin
      res.m_code       = MC_W'(best_m - M_MIN);
      res.p_code       = PC_W'(best_p - P_MIN);
      res.s_code       = SC_W'(best_s - 1);
      res.pll_word     = {res.m_code, 2'b00, res.p_code, 2'b00, res.s_code};
      res.achieved_khz = CLK_W'(best_clk);
      res.found        = 1'b1;
    end
    return res;
  endfunction

  function automatic req_row_t table_row(input logic [TGT_W-1:0] r, input logic [TGT_W-1:0] mn,
                                         input logic [TGT_W-1:0] mx, input logic [TGT_W-1:0] df,
                                         input logic [TGT_W-1:0] t, input logic typed,
                                         input pll_result_t exp);
    req_row_t row;
    row.ref_w  = r;
    row.min_w  = mn;
    row.max_w  = mx;
    row.dflt_w = df;
    row.target = t;
    row.typed  = typed;
    row.exp    = exp;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // drop valid and wait until every queued result has been taken
  task automatic wait_idle();
    if (src_active) begin
      in_ch.valid <= 1'b0;
      src_active = 1'b0;
      burst_left = 0;
    end
    while (queued_settings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TGT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_REF: cfg_ref  = value[REF_W-1:0];
      CFG_MIN: cfg_min  = value;
      CFG_MAX: cfg_max  = value;
      default: cfg_dflt = value;
    endcase
  endtask

  task automatic program_settings(input logic [TGT_W-1:0] r, input logic [TGT_W-1:0] mn,
                                  input logic [TGT_W-1:0] mx, input logic [TGT_W-1:0] df);
    wait_idle();
    write_reg(CFG_REF, r);
    write_reg(CFG_MIN, mn);
    write_reg(CFG_MAX, mx);
    write_reg(CFG_DFLT, df);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_request(input logic [TGT_W-1:0] t, input logic typed,
                              input pll_result_t exp);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 2))
        0:       gap = $urandom_range(1, 8);
        1:       gap = $urandom_range(20, 400);
        default: gap = $urandom_range(500, 6000);
      endcase
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 6);
    end
    in_ch.valid      <= 1'b1;
    in_ch.target_khz <= t;
    src_active = 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    queued_settings.push_back(typed ? exp : search_divider(t));
    requests_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      src_active = 1'b0;
    end
  endtask

  // receiver: mode picked after each transaction
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            stall_left   <= $urandom_range(1, MAX_STALL);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
    if (out_ch.valid && out_ch.ready) rx_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin : result_check
    pll_result_t want;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (queued_settings.size() == 0) begin
        report_mismatch("result with nothing queued", 32'(out_ch.pll_word), 32'd0);
      end else begin
        want = queued_settings.pop_front();
        check_field("m_code", 32'(out_ch.m_code), 32'(want.m_code));
        check_field("p_code", 32'(out_ch.p_code), 32'(want.p_code));
        check_field("s_code", 32'(out_ch.s_code), 32'(want.s_code));
        check_field("pll_word", 32'(out_ch.pll_word), 32'(want.pll_word));
        check_field("achieved_khz", 32'(out_ch.achieved_khz), 32'(want.achieved_khz));
        check_field("found", 32'(out_ch.found), 32'(want.found));
        results_seen++;
        if (!want.found) not_found++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i, ph, k;
    logic [TGT_W-1:0] r, mn, mx, df, t, tmp;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_REF;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.target_khz <= '0;

    // reset defaults
    dir_rows[0]  = table_row(10000, 10000, 66000, 60000, 66000, 1'b0, NOT_FOUND);
    dir_rows[1]  = table_row(10000, 10000, 66000, 60000, 66001, 1'b0, NOT_FOUND);
    // ref 2000 written with bit 17 set, full request window
    dir_rows[2]  = table_row(18'h207D0, 0, 262143, 8000, 0, 1'b1, NOT_FOUND);
    dir_rows[3]  = table_row(18'h207D0, 0, 262143, 8000, 1, 1'b1, NOT_FOUND);
    dir_rows[4]  = table_row(18'h207D0, 0, 262143, 8000, 8000, 1'b1, HIT_8000);
    dir_rows[5]  = table_row(18'h207D0, 0, 262143, 8000, 169999, 1'b0, NOT_FOUND);
    dir_rows[6]  = table_row(18'h207D0, 0, 262143, 8000, 170000, 1'b0, NOT_FOUND);
    dir_rows[7]  = table_row(18'h207D0, 0, 262143, 8000, 84999, 1'b0, NOT_FOUND);
    dir_rows[8]  = table_row(18'h207D0, 0, 262143, 8000, 85000, 1'b0, NOT_FOUND);
    dir_rows[9]  = table_row(18'h207D0, 0, 262143, 8000, 131072, 1'b0, NOT_FOUND);
    dir_rows[10] = table_row(18'h207D0, 0, 262143, 8000, 262143, 1'b0, NOT_FOUND);
    // window edges, out-of-window requests fall back to 8000
    dir_rows[11] = table_row(2000, 5000, 20000, 8000, 4999, 1'b1, HIT_8000);
    dir_rows[12] = table_row(2000, 5000, 20000, 8000, 5000, 1'b0, NOT_FOUND);
    dir_rows[13] = table_row(2000, 5000, 20000, 8000, 20000, 1'b0, NOT_FOUND);
    dir_rows[14] = table_row(2000, 5000, 20000, 8000, 20001, 1'b1, HIT_8000);
    // zero reference: empty search
    dir_rows[15] = table_row(0, 0, 262143, 1, 60000, 1'b1, NOT_FOUND);
    dir_rows[16] = table_row(0, 0, 262143, 1, 262143, 1'b1, NOT_FOUND);
    // largest reference: p range is empty; then ref 98000 with a single p
    dir_rows[17] = table_row(131071, 1, 169999, 169999, 50000, 1'b1, NOT_FOUND);
    dir_rows[18] = table_row(98000, 1, 169999, 1, 20000, 1'b0, NOT_FOUND);
    dir_rows[19] = table_row(98000, 1, 169999, 1, 0, 1'b0, NOT_FOUND);
    dir_rows[20] = table_row(98000, 1, 169999, 1, 169999, 1'b0, NOT_FOUND);
    // min above max: every request takes the default
    dir_rows[21] = table_row(3000, 50000, 40000, 169999, 45000, 1'b0, NOT_FOUND);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      if (dir_rows[i].ref_w[REF_W-1:0] != cfg_ref || dir_rows[i].min_w != cfg_min ||
          dir_rows[i].max_w != cfg_max || dir_rows[i].dflt_w != cfg_dflt)
        program_settings(dir_rows[i].ref_w, dir_rows[i].min_w, dir_rows[i].max_w,
                         dir_rows[i].dflt_w);
      send_request(dir_rows[i].target, dir_rows[i].typed, dir_rows[i].exp);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // mostly single-p references to keep the search short
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: r = TGT_W'($urandom_range(2000, 2999));
        7: r = TGT_W'($urandom_range(3000, 3999));
        8: begin
          if ($urandom_range(0, 1)) r = 0;
          else if ($urandom_range(0, 1)) r = 131071;
          else r = TGT_W'($urandom_range(98000, 99999));
        end
        default: r = TGT_W'($urandom_range(4000, 5999));
      endcase
      mn = TGT_W'($urandom_range(0, 20000));
      mx = TGT_W'($urandom_range(mn, 262143));
      if ($urandom_range(0, 7) == 0) begin
        tmp = mn;
        mn  = mx;
        mx  = tmp;
      end
      df = TGT_W'($urandom_range(0, 262143));
      program_settings(r, mn, mx, df);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == RAND_PHASES / 2 && k == ITEMS_PER_PHASE / 2) wait_idle();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: t = TGT_W'($urandom_range(0, 262143));
          5: t = cfg_min;
          6: t = cfg_min - 1'b1;
          7: t = cfg_max;
          8: t = cfg_max + 1'b1;
          default: t = TGT_W'($urandom_range(0, 25000));
        endcase
        send_request(t, 1'b0, NOT_FOUND);
      end
    end

    wait_idle();
    repeat (END_PAUSE) @(posedge clk);
    $display("Ran %0d requests (%0d from the table) across %0d register settings;",
             requests_sent, N_DIRECTED, settings_used);
    $display("%0d results checked, %0d of them with no setting found, %0d mismatches.",
             results_seen, not_found, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: pll_divider_search.f
rtl/pds_pkg.sv
rtl/pds_in_if.sv
rtl/pds_out_if.sv
rtl/pds_div.sv
rtl/pll_divider_search.sv
dv/tb_top.sv
